/* hw/rtl/dps_pkg.sv */
package dps_pkg;

	// item and register field widths
	localparam int REQ_W      = 3;
	localparam int NOW_W      = 32;
	localparam int MIN_W      = 11;
	localparam int WDAY_W     = 3;
	localparam int MDAY_W     = 5;
	localparam int VOL_W      = 16;
	localparam int PRIME_W    = 16;
	localparam int RATE_W     = 16;
	localparam int DAYS_W     = 7;
	localparam int DPD_W      = 3;
	localparam int NSLOT_W    = 4;   // slot count, up to 15
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int PACKED_SLOTS = 4;  // slots that have register bits

	// stream packing
	localparam int IN_DATA_W  = 88;   // 83 bits of fields, padded
	localparam int OUT_DATA_W = 24;   // 19 bits of fields, padded

	// run length: amount * 10000 / rate
	localparam int LEN_SCALE    = 10000;
	localparam int RATE_DEFAULT = 100;
	localparam int DVD_W        = 30; // 65535 * 10000 fits 30 bits
	localparam int DVS_W        = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK        = 3'd0,
		REQ_MANUAL      = 3'd1,
		REQ_PRIME_START = 3'd2,
		REQ_PRIME_STOP  = 3'd3,
		REQ_TIMED_PRIME = 3'd4
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE      = 3'd0,
		CFG_ENABLE    = 3'd1,
		CFG_DAYS      = 3'd2,
		CFG_DOSES     = 3'd3,
		CFG_MINUTES   = 3'd4,
		CFG_AMOUNTS   = 3'd5,
		CFG_DAILY     = 3'd6,
		CFG_RESERVOIR = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHARE_GO,
		ST_SHARE_WAIT,
		ST_MUL,
		ST_LEN_GO,
		ST_LEN_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

endpackage

/* hw/rtl/dps_div.sv */
module dps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dps_pkg::div_req_t req,
	output dps_pkg::div_rsp_t rsp
);
	import dps_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0] shifted;
	logic [DVS_W:0] diff;

	// restoring step: one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

/* hw/rtl/dosing_pump_scheduler.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: req_type; tdata: now, minute, wday, mday, amount, prime
// m_*       out  tvalid/tready      tdata: pump_on, remaining, run_started, run_finished
// cfg_*     in   cfg_wen strobe     cfg_idx selects register, cfg_data carries value
//
// Sequence: commands other than a manual dose, and ticks that skip the schedule, go
// straight to the result; a scanning tick visits each slot in use (up to MAX_SLOTS).
// A dose start adds a multiply and a 30-step serial divide, plus one more divide for a daily share.
// Reset: asynchronous, active low, for control and config registers; datapath registers have none.
// Stalls: the result waits in an output register while the next beat is taken; the
// sequencer holds in its final state only while that register is still full.
module dosing_pump_scheduler #(
	parameter int MAX_SLOTS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [2:0] req_type
	input  logic [dps_pkg::REQ_W-1:0]        s_tuser,
	// [31:0] now_ms, [42:32] minute_of_day, [45:43] weekday, [50:46] day_of_month,
	// [66:51] amount_deci_ml, [82:67] prime_ms, [87:83] zero
	input  logic [dps_pkg::IN_DATA_W-1:0]    s_tdata,
	// master stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] pump_on, [16:1] remaining_deci_ml, [17] run_started, [18] run_finished,
	// [23:19] zero
	output logic [dps_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration writes
	input  logic                             cfg_wen,
	input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dps_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dps_pkg::*;

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// ---------------- input unpack ----------------
	req_t               in_req;
	logic [NOW_W-1:0]   in_now;
	logic [MIN_W-1:0]   in_minute;
	logic [WDAY_W-1:0]  in_wday;
	logic [MDAY_W-1:0]  in_mday;
	logic [VOL_W-1:0]   in_amt;
	logic [PRIME_W-1:0] in_prime;

	assign in_req    = req_t'(s_tuser);
	assign in_now    = s_tdata[31:0];
	assign in_minute = s_tdata[42:32];
	assign in_wday   = s_tdata[45:43];
	assign in_mday   = s_tdata[50:46];
	assign in_amt    = s_tdata[66:51];
	assign in_prime  = s_tdata[82:67];

	// ---------------- configuration ----------------
	logic [RATE_W-1:0]        rate_q;
	logic                     enable_q;
	logic [DAYS_W-1:0]        days_q;
	logic [DPD_W-1:0]         doses_q;
	logic [4*MIN_W-1:0]       minutes_q;
	logic [4*VOL_W-1:0]       amounts_q;
	logic [VOL_W-1:0]         daily_q;

	// ---------------- channel state ----------------
	logic                     running_q;
	logic                     open_q;
	logic [NOW_W-1:0]         end_q;
	logic [VOL_W-1:0]         target_q;
	logic [VOL_W-1:0]         remaining_q;
	logic [MDAY_W-1:0]        last_day_q [MAX_SLOTS];

	// ---------------- per-item working registers ----------------
	state_t                   state_q, state_d;
	logic [NOW_W-1:0]         now_q;
	logic [MIN_W-1:0]         minute_q;
	logic [MDAY_W-1:0]        mday_q;
	logic [VOL_W-1:0]         amt_q;      // amount of the run being set up
	logic [DVD_W-1:0]         prod_q;     // amount * 10000
	logic [NSLOT_W-1:0]       idx_q;      // scan position
	logic                     hit_q;      // some slot matched so far
	logic                     start_q;
	logic                     fin_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	// ---------------- derived ----------------
	logic [MIN_W-1:0]         slot_min [MAX_SLOTS];
	logic [VOL_W-1:0]         slot_amt [MAX_SLOTS];
	logic [NSLOT_W-1:0]       slots_used;
	logic [SLOT_W-1:0]        slot_i;
	logic                     scan_hit;
	logic                     scan_last;
	logic [VOL_W-1:0]         scan_amt;
	logic                     scan_go;
	logic [DAYS_W:0]          days_ext;
	logic [RATE_W-1:0]        rate_eff;
	logic                     s_accept;
	logic                     out_load;
	logic                     tick_end;
	logic [VOL_W-1:0]         rem_after;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	// slots past the packed four have no register bits: minute 0, amount 0
	for (genvar d = 0; d < MAX_SLOTS; d++) begin : g_slot
		if (d < PACKED_SLOTS) begin : g_packed
			assign slot_min[d] = minutes_q[MIN_W*d +: MIN_W];
			assign slot_amt[d] = amounts_q[VOL_W*d +: VOL_W];
		end else begin : g_empty
			assign slot_min[d] = '0;
			assign slot_amt[d] = '0;
		end
	end

	// doses_per_day above MAX_SLOTS clamps, for the scan and the share
	assign slots_used = (NSLOT_W'(doses_q) > NSLOT_W'(MAX_SLOTS)) ?
		NSLOT_W'(MAX_SLOTS) : NSLOT_W'(doses_q);

	assign slot_i    = idx_q[SLOT_W-1:0];
	assign scan_hit  = (minute_q == slot_min[slot_i]) && (last_day_q[slot_i] != mday_q);
	assign scan_last = (idx_q + NSLOT_W'(1)) == slots_used;
	assign scan_amt  = scan_hit ? slot_amt[slot_i] : amt_q;

	// weekday 7 lands on the padding bit and never matches
	assign days_ext  = {1'b0, days_q};
	assign scan_go   = enable_q && days_ext[in_wday] && (slots_used != '0);

	assign rate_eff  = (rate_q == '0) ? RATE_W'(RATE_DEFAULT) : rate_q;

	assign s_accept  = s_tvalid && s_tready;
	assign tick_end  = running_q && !open_q && (in_now >= end_q);
	assign rem_after = (remaining_q > target_q) ? (remaining_q - target_q) : '0;

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_req == REQ_TICK) begin
						state_d = scan_go ? ST_SCAN : ST_DONE;
					end else if (in_req == REQ_MANUAL) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					if (!(hit_q || scan_hit)) begin
						state_d = ST_DONE;
					end else if (scan_amt == '0) begin
						state_d = ST_SHARE_GO;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_SHARE_GO: begin
				state_d = ST_SHARE_WAIT;
			end
			ST_SHARE_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_LEN_GO;
			end
			ST_LEN_GO: begin
				state_d = ST_LEN_WAIT;
			end
			ST_LEN_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		s_tready         = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = rate_eff;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SHARE_GO: begin
				// daily share = daily total / slots in use
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(daily_q);
				div_req.divisor  = DVS_W'(slots_used);
			end
			ST_LEN_GO: begin
				div_req.start = 1'b1;
			end
			ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// shared serial divider: daily share and run length
	dps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- control and channel state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= RATE_W'(RATE_DEFAULT);
			enable_q    <= 1'b0;
			days_q      <= '0;
			doses_q     <= '0;
			minutes_q   <= '0;
			amounts_q   <= '0;
			daily_q     <= '0;
			running_q   <= 1'b0;
			open_q      <= 1'b0;
			end_q       <= '0;
			target_q    <= '0;
			remaining_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				last_day_q[i] <= '0;
			end
			idx_q       <= '0;
			hit_q       <= 1'b0;
			start_q     <= 1'b0;
			fin_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wen) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_RATE:      rate_q      <= cfg_data[RATE_W-1:0];
					CFG_ENABLE:    enable_q    <= cfg_data[0];
					CFG_DAYS:      days_q      <= cfg_data[DAYS_W-1:0];
					CFG_DOSES:     doses_q     <= cfg_data[DPD_W-1:0];
					CFG_MINUTES:   minutes_q   <= cfg_data[4*MIN_W-1:0];
					CFG_AMOUNTS:   amounts_q   <= cfg_data[4*VOL_W-1:0];
					CFG_DAILY:     daily_q     <= cfg_data[VOL_W-1:0];
					CFG_RESERVOIR: remaining_q <= cfg_data[VOL_W-1:0];
				endcase
			end

			if (s_accept) begin
				idx_q   <= '0;
				hit_q   <= 1'b0;
				start_q <= 1'b0;
				fin_q   <= 1'b0;
				unique case (in_req)
					REQ_TICK: begin
						// timed run ends before the schedule is looked at
						if (tick_end) begin
							running_q   <= 1'b0;
							target_q    <= '0;
							remaining_q <= rem_after;
							fin_q       <= 1'b1;
						end
					end
					REQ_MANUAL: begin
						// run set up by the divider path
					end
					REQ_PRIME_START: begin
						running_q <= 1'b1;
						open_q    <= 1'b1;
						end_q     <= '0;
						target_q  <= '0;
						start_q   <= 1'b1;
					end
					REQ_PRIME_STOP: begin
						running_q <= 1'b0;
						open_q    <= 1'b0;
						end_q     <= '0;
						target_q  <= '0;
					end
					REQ_TIMED_PRIME: begin
						running_q <= 1'b1;
						open_q    <= 1'b0;
						end_q     <= in_now + NOW_W'(in_prime);
						target_q  <= '0;
						start_q   <= 1'b1;
					end
					default: begin
						// unknown request: report state only
					end
				endcase
			end

			// every matching slot is marked done today; the last one sets the run
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + NSLOT_W'(1);
				if (scan_hit) begin
					last_day_q[slot_i] <= mday_q;
					hit_q              <= 1'b1;
				end
			end

			// new run replaces any current one without charging it
			if ((state_q == ST_LEN_WAIT) && div_rsp.done) begin
				running_q <= 1'b1;
				open_q    <= 1'b0;
				end_q     <= now_q + NOW_W'(div_rsp.quot);
				target_q  <= amt_q;
				start_q   <= 1'b1;
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_accept) begin
			now_q    <= in_now;
			minute_q <= in_minute;
			mday_q   <= in_mday;
			amt_q    <= in_amt;
		end
		if ((state_q == ST_SCAN) && scan_hit) begin
			amt_q <= slot_amt[slot_i];
		end
		if ((state_q == ST_SHARE_WAIT) && div_rsp.done) begin
			amt_q <= div_rsp.quot[VOL_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= DVD_W'(amt_q) * DVD_W'(LEN_SCALE);
		end
		if (out_load) begin
			m_tdata_q <= {5'b0, fin_q, start_q, remaining_q, running_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hw/rtl/dps_checker.sv */
module dps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [dps_pkg::OUT_DATA_W-1:0] m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one item in flight: ready drops right after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// a started run leaves the pump on
	a_start_on: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[0])
		else $error("run started but pump off");

	// a finished run with no restart leaves the pump off
	a_finish_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] && !m_tdata[17] |-> !m_tdata[0])
		else $error("run finished but pump still on");

endmodule

bind dosing_pump_scheduler dps_checker u_dps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
